// ===== rtl/core/rlr_pkg.sv =====
`timescale 1ns / 1ps

package rlr_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int GROUP_DEPTH  = 24;
	localparam int ADDR_WIDTH   = $clog2(GROUP_DEPTH);
	localparam int WEIGHT_WIDTH = 5;
	localparam int ACC_WIDTH    = SAMPLE_WIDTH + WEIGHT_WIDTH;
	localparam int STEP_WIDTH   = 5;
	localparam int FILL_WIDTH   = 5;
	localparam int MODE_WIDTH   = 3;
	localparam int PADDR_WIDTH  = 3;
	localparam int PDATA_WIDTH  = 32;

	localparam int RECIP_SHIFT  = ACC_WIDTH + 1;
	localparam int RECIP_WIDTH  = RECIP_SHIFT + 1;
	localparam int PROD_WIDTH   = ACC_WIDTH + RECIP_WIDTH;

	localparam int DIVISOR_3    = 3;
	localparam int DIVISOR_5    = 5;
	localparam int DIVISOR_25   = 25;

	localparam logic [RECIP_WIDTH-1:0] RECIP_1  = RECIP_WIDTH'(64'd1 << RECIP_SHIFT);
	localparam logic [RECIP_WIDTH-1:0] RECIP_3  =
		RECIP_WIDTH'((64'd1 << RECIP_SHIFT) / DIVISOR_3);
	localparam logic [RECIP_WIDTH-1:0] RECIP_5  =
		RECIP_WIDTH'((64'd1 << RECIP_SHIFT) / DIVISOR_5);
	localparam logic [RECIP_WIDTH-1:0] RECIP_25 =
		RECIP_WIDTH'((64'd1 << RECIP_SHIFT) / DIVISOR_25);

	localparam int SIZE_6_5   = 6;
	localparam int SIZE_4_3   = 4;
	localparam int SIZE_24_25 = 24;
	localparam int SIZE_4_5   = 4;

	localparam int LAST_STEP_5  = 4;
	localparam int LAST_STEP_3  = 2;
	localparam int LAST_STEP_25 = 24;

	localparam logic REG_RATIO_MODE = 1'b0;

	typedef enum logic [MODE_WIDTH-1:0] {
		MODE_6_5   = 3'd0,
		MODE_4_3   = 3'd1,
		MODE_24_25 = 3'd2,
		MODE_4_5   = 3'd3,
		MODE_PASS  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		DIV_1,
		DIV_3,
		DIV_5,
		DIV_25
	} div_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PASS,
		ST_READ,
		ST_MAC_A,
		ST_MAC_B,
		ST_DIV,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic [ADDR_WIDTH-1:0]   ia;
		logic [ADDR_WIDTH-1:0]   ib;
		logic [WEIGHT_WIDTH-1:0] wa;
		logic [WEIGHT_WIDTH-1:0] wb;
		div_t                    div;
		logic                    last;
	} step_t;

	function automatic logic is_pass(input logic [MODE_WIDTH-1:0] mode);
		logic r;
		unique case (mode) inside
			MODE_6_5, MODE_4_3, MODE_24_25, MODE_4_5: r = 1'b0;
			default: r = 1'b1;
		endcase
		return r;
	endfunction

	function automatic logic [FILL_WIDTH-1:0] group_size(input logic [MODE_WIDTH-1:0] mode);
		logic [FILL_WIDTH-1:0] r;
		unique case (mode)
			MODE_6_5:   r = FILL_WIDTH'(SIZE_6_5);
			MODE_4_3:   r = FILL_WIDTH'(SIZE_4_3);
			MODE_24_25: r = FILL_WIDTH'(SIZE_24_25);
			MODE_4_5:   r = FILL_WIDTH'(SIZE_4_5);
			default:    r = FILL_WIDTH'(1);
		endcase
		return r;
	endfunction

	function automatic logic [WEIGHT_WIDTH-1:0] div_value(input div_t div);
		logic [WEIGHT_WIDTH-1:0] r;
		unique case (div)
			DIV_3:   r = WEIGHT_WIDTH'(DIVISOR_3);
			DIV_5:   r = WEIGHT_WIDTH'(DIVISOR_5);
			DIV_25:  r = WEIGHT_WIDTH'(DIVISOR_25);
			default: r = WEIGHT_WIDTH'(1);
		endcase
		return r;
	endfunction

	function automatic logic [RECIP_WIDTH-1:0] div_recip(input div_t div);
		logic [RECIP_WIDTH-1:0] r;
		unique case (div)
			DIV_3:   r = RECIP_3;
			DIV_5:   r = RECIP_5;
			DIV_25:  r = RECIP_25;
			default: r = RECIP_1;
		endcase
		return r;
	endfunction

	function automatic step_t mix(input int ia, input int wa, input int ib, input int wb,
			input div_t div, input logic last);
		step_t s;
		s.ia   = ADDR_WIDTH'(ia);
		s.ib   = ADDR_WIDTH'(ib);
		s.wa   = WEIGHT_WIDTH'(wa);
		s.wb   = WEIGHT_WIDTH'(wb);
		s.div  = div;
		s.last = last;
		return s;
	endfunction

	// A copied sample is a mix with unit weight on one entry and a divisor of one.
	function automatic step_t step_info(input logic [MODE_WIDTH-1:0] mode,
			input logic [STEP_WIDTH-1:0] j);
		step_t s;
		int    ji;
		ji = int'(j);
		s  = mix(0, 1, 0, 0, DIV_1, 1'b0);
		unique case (mode)
			MODE_6_5: begin
				unique case (ji)
					0: s = mix(0, 1, 0, 0, DIV_1, 1'b0);
					1: s = mix(1, 4, 2, 1, DIV_5, 1'b0);
					2: s = mix(2, 3, 3, 2, DIV_5, 1'b0);
					3: s = mix(3, 2, 4, 3, DIV_5, 1'b0);
					default: s = mix(4, 1, 5, 4, DIV_5, 1'b1);
				endcase
			end
			MODE_4_3: begin
				unique case (ji)
					0: s = mix(0, 1, 0, 0, DIV_1, 1'b0);
					1: s = mix(1, 2, 2, 1, DIV_3, 1'b0);
					default: s = mix(2, 1, 3, 2, DIV_3, 1'b1);
				endcase
			end
			MODE_24_25: begin
				if (ji == 0) begin
					s = mix(0, 1, 0, 0, DIV_1, 1'b0);
				end else if (ji >= LAST_STEP_25) begin
					s = mix(SIZE_24_25 - 1, 1, 0, 0, DIV_1, 1'b1);
				end else begin
					s = mix(ji - 1, ji, ji, DIVISOR_25 - ji, DIV_25, 1'b0);
				end
			end
			default: begin
				unique case (ji)
					0: s = mix(0, 1, 0, 0, DIV_1, 1'b0);
					1: s = mix(0, 1, 1, 4, DIV_5, 1'b0);
					2: s = mix(1, 2, 2, 3, DIV_5, 1'b0);
					3: s = mix(2, 3, 3, 2, DIV_5, 1'b0);
					default: s = mix(3, 1, 0, 0, DIV_1, 1'b1);
				endcase
			end
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/rlr_cdiv.sv =====
`timescale 1ns / 1ps

module rlr_cdiv (
	input  logic                              clk,
	input  logic                              load,
	input  logic [rlr_pkg::ACC_WIDTH-1:0]     dividend,
	input  rlr_pkg::div_t                     div,
	output logic [rlr_pkg::SAMPLE_WIDTH-1:0]  quotient
);

	logic [rlr_pkg::PROD_WIDTH-1:0]   product_s1;
	logic [rlr_pkg::ACC_WIDTH-1:0]    dividend_s1;
	rlr_pkg::div_t                    div_s1;
	logic [rlr_pkg::ACC_WIDTH-1:0]    q_est;
	logic [rlr_pkg::ACC_WIDTH-1:0]    q_back;
	logic [rlr_pkg::ACC_WIDTH-1:0]    remainder;
	logic [rlr_pkg::ACC_WIDTH-1:0]    divisor;
	logic [rlr_pkg::ACC_WIDTH-1:0]    q_fixed;

	always_ff @(posedge clk) begin
		if (load) begin
			product_s1  <= rlr_pkg::PROD_WIDTH'(dividend) *
				rlr_pkg::PROD_WIDTH'(rlr_pkg::div_recip(div));
			dividend_s1 <= dividend;
			div_s1      <= div;
		end
	end

	// The reciprocal estimate is low by at most one; a single compare fixes it.
	always_comb begin
		q_est     = product_s1[rlr_pkg::RECIP_SHIFT +: rlr_pkg::ACC_WIDTH];
		divisor   = rlr_pkg::ACC_WIDTH'(rlr_pkg::div_value(div_s1));
		q_back    = rlr_pkg::ACC_WIDTH'(q_est * divisor);
		remainder = dividend_s1 - q_back;
		q_fixed   = (remainder >= divisor) ? q_est + rlr_pkg::ACC_WIDTH'(1) : q_est;
		quotient  = q_fixed[rlr_pkg::SAMPLE_WIDTH-1:0];
	end

endmodule

// ===== rtl/core/rational_linear_resampler_unit.sv =====
`timescale 1ns / 1ps

// Rational linear resampler. Samples enter one beat at a time and are stored until
// the group for the selected ratio is complete (6, 4, 24 or 4 samples for the
// 6:5, 4:3, 24:25 and 4:5 modes); the group's 5, 3, 25 or 5 results then leave
// one by one, with last_of_group on the final one. Each result passes through the
// shared datapath in order: a store read, two multiply-accumulate steps on one
// weight multiplier, a reciprocal multiply, and a correcting compare that writes
// the output register, which waits while the output side stalls. In pass-through
// mode (ratio_mode 4 and the unused codes) a registered sample is copied to the
// output register. in_stall is high in every state but idle, that is while results
// are being produced and while a pass-through sample is forwarded; the last result
// of a group may wait in the output register while the next sample is taken.
// buffer_end on a sample that does not complete a group drops the partial group,
// and so does any write of ratio_mode.
module rational_linear_resampler_unit (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rlr_pkg::PADDR_WIDTH-1:0]     paddr,
	input  logic [rlr_pkg::PDATA_WIDTH-1:0]     pwdata,
	output logic [rlr_pkg::PDATA_WIDTH-1:0]     prdata,
	output logic                                pready,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rlr_pkg::SAMPLE_WIDTH-1:0]    in_sample,
	input  logic                                buffer_end,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rlr_pkg::SAMPLE_WIDTH-1:0]    out_sample,
	output logic                                last_of_group
);

	rlr_pkg::state_t                          state_q;
	rlr_pkg::state_t                          state_next;
	logic [rlr_pkg::MODE_WIDTH-1:0]           ratio_mode_q;
	logic [rlr_pkg::FILL_WIDTH-1:0]           fill_q;
	logic [rlr_pkg::STEP_WIDTH-1:0]           step_q;
	logic [rlr_pkg::SAMPLE_WIDTH-1:0]         sample_q;
	logic [rlr_pkg::SAMPLE_WIDTH-1:0]         store_q [rlr_pkg::GROUP_DEPTH];
	logic [rlr_pkg::SAMPLE_WIDTH-1:0]         rd_a_q;
	logic [rlr_pkg::SAMPLE_WIDTH-1:0]         rd_b_q;
	logic [rlr_pkg::ACC_WIDTH-1:0]            acc_q;
	logic                                     out_valid_q;
	logic [rlr_pkg::SAMPLE_WIDTH-1:0]         out_sample_q;
	logic                                     out_last_q;

	rlr_pkg::step_t                           step;
	logic                                     cfg_write;
	logic                                     in_fire;
	logic                                     mode_pass;
	logic                                     group_done;
	logic                                     slot_free;
	logic                                     out_load;
	logic                                     div_load;
	logic [rlr_pkg::WEIGHT_WIDTH-1:0]         mac_weight;
	logic [rlr_pkg::SAMPLE_WIDTH-1:0]         mac_sample;
	logic [rlr_pkg::ACC_WIDTH-1:0]            mac_product;
	logic [rlr_pkg::SAMPLE_WIDTH-1:0]         quotient;

	assign pready     = 1'b1;
	assign cfg_write  = psel && penable && pwrite && (paddr[2] == rlr_pkg::REG_RATIO_MODE);
	assign prdata     = (paddr[2] == rlr_pkg::REG_RATIO_MODE) ?
		rlr_pkg::PDATA_WIDTH'(ratio_mode_q) : '0;

	assign in_fire    = in_valid && !in_stall;
	assign mode_pass  = rlr_pkg::is_pass(ratio_mode_q);
	assign group_done = (fill_q + rlr_pkg::FILL_WIDTH'(1)) == rlr_pkg::group_size(ratio_mode_q);
	assign slot_free  = !out_valid_q || !out_stall;
	assign step       = rlr_pkg::step_info(ratio_mode_q, step_q);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			rlr_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (mode_pass) begin
						state_next = rlr_pkg::ST_PASS;
					end else if (group_done) begin
						state_next = rlr_pkg::ST_READ;
					end
				end
			end
			rlr_pkg::ST_PASS: begin
				if (slot_free) begin
					state_next = rlr_pkg::ST_IDLE;
				end
			end
			rlr_pkg::ST_READ:  state_next = rlr_pkg::ST_MAC_A;
			rlr_pkg::ST_MAC_A: state_next = rlr_pkg::ST_MAC_B;
			rlr_pkg::ST_MAC_B: state_next = rlr_pkg::ST_DIV;
			rlr_pkg::ST_DIV:   state_next = rlr_pkg::ST_WRITE;
			rlr_pkg::ST_WRITE: begin
				if (slot_free) begin
					state_next = step.last ? rlr_pkg::ST_IDLE : rlr_pkg::ST_READ;
				end
			end
			default: state_next = rlr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		div_load = 1'b0;
		unique case (state_q)
			rlr_pkg::ST_IDLE:  in_stall = 1'b0;
			rlr_pkg::ST_PASS:  out_load = slot_free;
			rlr_pkg::ST_DIV:   div_load = 1'b1;
			rlr_pkg::ST_WRITE: out_load = slot_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_mode_q <= rlr_pkg::MODE_PASS;
			fill_q       <= '0;
		end else if (cfg_write) begin
			ratio_mode_q <= pwdata[rlr_pkg::MODE_WIDTH-1:0];
			fill_q       <= '0;
		end else if (in_fire) begin
			if (mode_pass || group_done || buffer_end) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_q + rlr_pkg::FILL_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (in_fire) begin
			step_q <= '0;
		end else if (out_load && (state_q == rlr_pkg::ST_WRITE) && !step.last) begin
			step_q <= step_q + rlr_pkg::STEP_WIDTH'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= in_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !mode_pass) begin
			store_q[fill_q[rlr_pkg::ADDR_WIDTH-1:0]] <= in_sample;
		end
		rd_a_q <= store_q[step.ia];
		rd_b_q <= store_q[step.ib];
	end

	assign mac_weight  = (state_q == rlr_pkg::ST_MAC_A) ? step.wa : step.wb;
	assign mac_sample  = (state_q == rlr_pkg::ST_MAC_A) ? rd_a_q : rd_b_q;
	assign mac_product = rlr_pkg::ACC_WIDTH'(mac_weight) * rlr_pkg::ACC_WIDTH'(mac_sample);

	always_ff @(posedge clk) begin
		if (state_q == rlr_pkg::ST_MAC_A) begin
			acc_q <= mac_product;
		end else if (state_q == rlr_pkg::ST_MAC_B) begin
			acc_q <= acc_q + mac_product;
		end
	end

	rlr_cdiv u_cdiv (
		.clk      (clk),
		.load     (div_load),
		.dividend (acc_q),
		.div      (step.div),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == rlr_pkg::ST_PASS) begin
				out_sample_q <= sample_q;
				out_last_q   <= 1'b1;
			end else begin
				out_sample_q <= quotient;
				out_last_q   <= step.last;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_sample    = out_sample_q;
	assign last_of_group = out_last_q;

`ifndef ASSERT_OFF
	a_pass_goes_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mode_pass) |=> (state_q == rlr_pkg::ST_PASS))
		else $error("pass-through beat did not reach the output state");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= rlr_pkg::STEP_WIDTH'(rlr_pkg::LAST_STEP_25))
		else $error("result step counter ran past the longest group");

	a_fill_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rlr_pkg::ST_IDLE) |-> (fill_q < rlr_pkg::group_size(ratio_mode_q)))
		else $error("fill count reached the group size while idle");
`endif

endmodule

// ===== tb/sv/tb_rational_linear_resampler_unit.sv =====
`timescale 1ns / 1ps

module tb_rational_linear_resampler_unit;

	localparam logic [rlr_pkg::PADDR_WIDTH-1:0] ADDR_RATIO_MODE = 3'd0;
	localparam logic [rlr_pkg::PADDR_WIDTH-1:0] ADDR_UNMAPPED   = 3'd4;

	localparam logic [rlr_pkg::MODE_WIDTH-1:0] MODE_RSVD_5 = 3'd5;
	localparam logic [rlr_pkg::MODE_WIDTH-1:0] MODE_RSVD_6 = 3'd6;
	localparam logic [rlr_pkg::MODE_WIDTH-1:0] MODE_RSVD_7 = 3'd7;

	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 35;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [rlr_pkg::SAMPLE_WIDTH-1:0] sample;
		logic                             bend;
	} sample_beat_t;

	typedef struct {
		logic [rlr_pkg::SAMPLE_WIDTH-1:0] sample;
		logic                             last;
	} resampled_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [rlr_pkg::PADDR_WIDTH-1:0]  paddr = '0;
	logic [rlr_pkg::PDATA_WIDTH-1:0]  pwdata = '0;
	logic [rlr_pkg::PDATA_WIDTH-1:0]  prdata;
	logic                             pready;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [rlr_pkg::SAMPLE_WIDTH-1:0] in_sample = '0;
	logic                             buffer_end = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [rlr_pkg::SAMPLE_WIDTH-1:0] out_sample;
	logic                             last_of_group;

	sample_beat_t                     pending_samples[$];
	resampled_t                       expected_outputs[$];
	int                               send_idle_pct = 0;
	int                               recv_stall_pct = 0;
	int                               mismatches = 0;
	int                               cycles = 0;

	logic [rlr_pkg::MODE_WIDTH-1:0]   model_mode = rlr_pkg::MODE_PASS;
	logic [rlr_pkg::SAMPLE_WIDTH-1:0] model_store [rlr_pkg::GROUP_DEPTH];
	int                               model_fill = 0;

	rational_linear_resampler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_sample(in_sample),
		.buffer_end(buffer_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_sample(out_sample),
		.last_of_group(last_of_group)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int group_len(input logic [rlr_pkg::MODE_WIDTH-1:0] mode);
		case (mode)
			rlr_pkg::MODE_6_5:   return rlr_pkg::SIZE_6_5;
			rlr_pkg::MODE_4_3:   return rlr_pkg::SIZE_4_3;
			rlr_pkg::MODE_24_25: return rlr_pkg::SIZE_24_25;
			rlr_pkg::MODE_4_5:   return rlr_pkg::SIZE_4_5;
			default:             return 1;
		endcase
	endfunction

	function automatic logic [rlr_pkg::SAMPLE_WIDTH-1:0] blend(input int wa, input int ia,
			input int wb, input int ib, input int divisor);
		int acc;
		acc = wa * int'(model_store[ia]) + wb * int'(model_store[ib]);
		return rlr_pkg::SAMPLE_WIDTH'(acc / divisor);
	endfunction

	function automatic void emit_group();
		logic [rlr_pkg::SAMPLE_WIDTH-1:0] vals[$];
		int pos;
		int base;
		int frac;
		case (model_mode)
			rlr_pkg::MODE_6_5: begin
				vals.push_back(model_store[0]);
				vals.push_back(blend(4, 1, 1, 2, rlr_pkg::DIVISOR_5));
				vals.push_back(blend(3, 2, 2, 3, rlr_pkg::DIVISOR_5));
				vals.push_back(blend(2, 3, 3, 4, rlr_pkg::DIVISOR_5));
				vals.push_back(blend(1, 4, 4, 5, rlr_pkg::DIVISOR_5));
			end
			rlr_pkg::MODE_4_3: begin
				vals.push_back(model_store[0]);
				vals.push_back(blend(2, 1, 1, 2, rlr_pkg::DIVISOR_3));
				vals.push_back(blend(1, 2, 2, 3, rlr_pkg::DIVISOR_3));
			end
			rlr_pkg::MODE_24_25: begin
				for (int j = 0; j < rlr_pkg::DIVISOR_25; j++) begin
					pos = j * rlr_pkg::SIZE_24_25;
					base = pos / rlr_pkg::DIVISOR_25;
					frac = pos % rlr_pkg::DIVISOR_25;
					if (frac == 0 || base + 1 >= rlr_pkg::SIZE_24_25) begin
						vals.push_back(model_store[base]);
					end else begin
						vals.push_back(blend(rlr_pkg::DIVISOR_25 - frac, base, frac,
							base + 1, rlr_pkg::DIVISOR_25));
					end
				end
			end
			default: begin
				vals.push_back(model_store[0]);
				vals.push_back(blend(1, 0, 4, 1, rlr_pkg::DIVISOR_5));
				vals.push_back(blend(2, 1, 3, 2, rlr_pkg::DIVISOR_5));
				vals.push_back(blend(3, 2, 2, 3, rlr_pkg::DIVISOR_5));
				vals.push_back(model_store[3]);
			end
		endcase
		foreach (vals[k]) begin
			expected_outputs.push_back('{vals[k], k == vals.size() - 1});
		end
	endfunction

	function automatic void resample_beat(input logic [rlr_pkg::SAMPLE_WIDTH-1:0] s,
			input logic bend);
		int size;
		if (model_mode > rlr_pkg::MODE_4_5) begin
			model_fill = 0;
			expected_outputs.push_back('{s, 1'b1});
			return;
		end
		size = group_len(model_mode);
		if (model_fill >= size) begin
			model_fill = 0;
		end
		model_store[model_fill] = s;
		model_fill++;
		if (model_fill >= size) begin
			model_fill = 0;
			emit_group();
		end else if (bend) begin
			model_fill = 0;
		end
	endfunction

	always @(posedge clk) begin : driver
		sample_beat_t next_beat;
		if (in_valid && !in_stall) begin
			resample_beat(in_sample, buffer_end);
		end
		if (arst_n && (!in_valid || !in_stall)) begin
			if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_beat = pending_samples.pop_front();
				in_valid <= 1'b1;
				in_sample <= next_beat.sample;
				buffer_end <= next_beat.bend;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		resampled_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_outputs.size() == 0) begin
				$error("unexpected beat: out_sample %h last_of_group %b", out_sample,
					last_of_group);
				mismatches++;
			end else begin
				want = expected_outputs.pop_front();
				if (out_sample !== want.sample) begin
					$error("out_sample: expected %h, actual %h", want.sample, out_sample);
					mismatches++;
				end
				if (last_of_group !== want.last) begin
					$error("last_of_group: expected %b, actual %b", want.last, last_of_group);
					mismatches++;
				end
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic apb_access(input logic [rlr_pkg::PADDR_WIDTH-1:0] addr, input logic wr,
			input logic [rlr_pkg::PDATA_WIDTH-1:0] data,
			output logic [rlr_pkg::PDATA_WIDTH-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_register(input logic [rlr_pkg::PADDR_WIDTH-1:0] addr,
			input logic [rlr_pkg::MODE_WIDTH-1:0] mode);
		logic [rlr_pkg::PDATA_WIDTH-1:0] data;
		logic [rlr_pkg::PDATA_WIDTH-1:0] readback;
		data = $urandom();
		data[rlr_pkg::MODE_WIDTH-1:0] = mode;
		apb_access(addr, 1'b1, data, readback);
		if (addr == ADDR_RATIO_MODE) begin
			model_mode = mode;
			model_fill = 0;
		end
		apb_access(ADDR_RATIO_MODE, 1'b0, '0, readback);
		if (readback[rlr_pkg::MODE_WIDTH-1:0] !== model_mode) begin
			$error("ratio_mode: expected %0d, actual %0d", model_mode,
				readback[rlr_pkg::MODE_WIDTH-1:0]);
			mismatches++;
		end
	endtask

	task automatic send(input logic [rlr_pkg::SAMPLE_WIDTH-1:0] s, input logic bend);
		pending_samples.push_back('{s, bend});
	endtask

	task automatic wait_idle();
		while (pending_samples.size() != 0 || in_valid || expected_outputs.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [rlr_pkg::SAMPLE_WIDTH-1:0] pick_sample();
		int r;
		r = $urandom_range(99);
		if (r < 12) begin
			return '0;
		end
		if (r < 24) begin
			return '1;
		end
		return rlr_pkg::SAMPLE_WIDTH'($urandom_range(65535));
	endfunction

	initial begin : stimulus
		logic [rlr_pkg::MODE_WIDTH-1:0] phase_modes [PHASES];
		logic [rlr_pkg::MODE_WIDTH-1:0] mode;
		logic                           bend;
		int                             budget;
		int                             len;
		int                             size;
		int                             r;
		phase_modes = '{rlr_pkg::MODE_6_5, rlr_pkg::MODE_4_3, rlr_pkg::MODE_24_25,
			rlr_pkg::MODE_4_5, rlr_pkg::MODE_PASS, rlr_pkg::MODE_24_25, MODE_RSVD_5,
			rlr_pkg::MODE_6_5, rlr_pkg::MODE_4_5, MODE_RSVD_6, rlr_pkg::MODE_4_3,
			rlr_pkg::MODE_24_25};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pass-through straight out of reset, then an unused mode code.
		send('1, 1'b1);
		send('0, 1'b0);
		wait_idle();
		write_register(ADDR_RATIO_MODE, MODE_RSVD_7);
		send(16'hAAAA, 1'b0);
		wait_idle();

		// A full group still completes when buffer_end marks its last beat.
		write_register(ADDR_RATIO_MODE, rlr_pkg::MODE_6_5);
		repeat (5) send('1, 1'b0);
		send('1, 1'b1);
		send(16'h1234, 1'b0);
		send(16'h4321, 1'b1);
		wait_idle();

		// A mode write drops the partial group; a write to an unmapped address does not.
		write_register(ADDR_RATIO_MODE, rlr_pkg::MODE_4_3);
		send(16'h5555, 1'b0);
		wait_idle();
		write_register(ADDR_RATIO_MODE, rlr_pkg::MODE_4_3);
		send('0, 1'b0);
		send('1, 1'b0);
		wait_idle();
		write_register(ADDR_UNMAPPED, rlr_pkg::MODE_6_5);
		send('1, 1'b0);
		send('0, 1'b0);
		wait_idle();

		write_register(ADDR_RATIO_MODE, rlr_pkg::MODE_4_5);
		send('1, 1'b0);
		send('0, 1'b0);
		send('1, 1'b0);
		send('1, 1'b0);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			mode = phase_modes[p];
			write_register(ADDR_RATIO_MODE, mode);
			if (p == PHASES / 2) begin
				write_register(ADDR_UNMAPPED, MODE_RSVD_7);
			end
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 82;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 82;
				end
				default: begin
					send_idle_pct = 29;
					recv_stall_pct = 29;
				end
			endcase
			size = group_len(mode);
			budget = PHASE_ITEMS;
			while (budget > 0) begin
				r = $urandom_range(99);
				if (mode > rlr_pkg::MODE_4_5) begin
					send(pick_sample(), 1'($urandom_range(1)));
					budget--;
				end else begin
					if (r < 75) begin
						len = size;
						bend = ($urandom_range(3) == 0);
					end else if (r < 90) begin
						len = $urandom_range(size - 1, 1);
						bend = 1'b1;
					end else begin
						len = 1;
						bend = 1'($urandom_range(1));
					end
					for (int k = 0; k < len; k++) begin
						send(pick_sample(), (k == len - 1) ? bend : 1'b0);
					end
					budget -= len;
				end
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_outputs.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
